### hdl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained counting hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int MAX_BUCKETS  = 256;
  localparam int POOL_ENTRIES = 1024;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int BCNT_W  = 9;                        // bucket_count register
  localparam int BKT_W   = $clog2(MAX_BUCKETS);      // bucket index
  localparam int IDX_W   = $clog2(POOL_ENTRIES);     // pool index
  localparam int PTR_W   = IDX_W + 1;                // pool index or null

  // Remainder unit: two quotient bits per cycle over the key magnitude.
  localparam int MOD_BITS_PER_CYC = 2;
  localparam int MOD_CYC          = KEY_W / MOD_BITS_PER_CYC;
  localparam int MOD_CNT_W        = $clog2(MOD_CYC);

  localparam int BCNT_RESET = 100;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [BCNT_W-1:0]       bcnt_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [BKT_W-1:0]        bkt_t;

  localparam ptr_t   LINK_NULL = PTR_W'(POOL_ENTRIES);
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_CHAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    count_t           cnt;
    ptr_t             link;
  } entry_t;

endpackage

### hdl/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// Multi-cycle remainder of |key| by the clamped bucket count.
// ----------------------------------------------------------------------------
module cht_mod (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cht_pkg::key_t       key,
  input  cht_pkg::bcnt_t      bucket_count,
  output logic                done,
  output cht_pkg::bcnt_t      rem
);
  import cht_pkg::*;

  logic [KEY_W-1:0]     dvd;
  bcnt_t                dsr;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic [KEY_W-1:0]     mag;
  bcnt_t                dsr_eff;
  bcnt_t                rem_a;
  bcnt_t                rem_b;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  function automatic bcnt_t mod_step(bcnt_t r, logic b, bcnt_t n);
    logic [BCNT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      return BCNT_W'(t - {1'b0, n});
    end
    return BCNT_W'(t);
  endfunction

  always_comb begin
    mag = key[KEY_W-1] ? KEY_W'(-key) : KEY_W'(key);
    if (bucket_count == '0) begin
      dsr_eff = BCNT_W'(1);
    end else if (bucket_count > BCNT_W'(MAX_BUCKETS)) begin
      dsr_eff = BCNT_W'(MAX_BUCKETS);
    end else begin
      dsr_eff = bucket_count;
    end
    rem_a = mod_step(rem, dvd[KEY_W-1], dsr);
    rem_b = mod_step(rem_a, dvd[KEY_W-2], dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MOD_CNT_W'(MOD_CYC - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= mag;
      dsr <= dsr_eff;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << MOD_BITS_PER_CYC;
      rem <= rem_b;
    end
  end

endmodule

### hdl/chained_counting_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_counting_hash_table_unit
// Counting multiset of signed 32-bit keys in a separately chained hash table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     command, key
//   output    out        out_valid / out_stall   count, found, pool_full
//   config    in         cfg_we                  cfg_wdata (bucket_count)
//
// One transaction at a time. From accept to result a transaction passes the
// remainder unit (sixteen steps of two bits of |key|, then a flag that the
// remainder is ready), one head memory read, one entry memory read per
// chain entry visited and the hand-over of the result. Reset clears the
// bucket head valid bits and the pool fill count; the pool memory is never
// cleared, only entries below the fill count are ever linked. The result
// register frees the core, so a new transaction can be accepted while the
// previous result is still stalled.
// ----------------------------------------------------------------------------
module chained_counting_hash_table_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            command,
  input  cht_pkg::key_t   key,
  output logic            out_valid,
  input  logic            out_stall,
  output cht_pkg::count_t count,
  output logic            found,
  output logic            pool_full,
  input  logic            cfg_we,
  input  cht_pkg::bcnt_t  cfg_wdata
);
  import cht_pkg::*;

  state_t state;
  state_t state_next;

  bcnt_t  bucket_count;

  // Latched transaction
  cmd_t   cmd_q;
  key_t   key_q;

  // Remainder unit
  logic   mod_done;
  bcnt_t  mod_rem;
  bkt_t   bucket;

  // Bucket heads: memory plus per-bucket valid flops (invalid reads as null)
  ptr_t                   head_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_vld;
  ptr_t                   head_rd;
  logic                   head_vld_rd;
  logic                   head_we;
  ptr_t                   head_now;
  ptr_t                   head_q;

  // Pool entries
  entry_t entry_mem [POOL_ENTRIES];
  entry_t ent_rd;
  idx_t   ent_raddr;
  logic   ent_we;
  idx_t   ent_waddr;
  entry_t ent_wdata;
  ptr_t   ptr;
  ptr_t   next_free;

  // Walk decisions
  logic   accept;
  logic   chain_hit;
  logic   chain_end;
  logic   resolve;
  logic   pool_empty;
  count_t cnt_inc;
  ptr_t   link_in;

  // Result
  count_t res_count;
  logic   res_found;
  logic   res_full;
  count_t res_count_next;
  logic   res_found_next;
  logic   res_full_next;
  logic   out_free;
  logic   out_load;

  // Hold the input off during reset so that no transaction is dropped there.
  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign bucket   = mod_rem[BKT_W-1:0];

  cht_mod u_mod (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .key          (key),
    .bucket_count (bucket_count),
    .done         (mod_done),
    .rem          (mod_rem)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BCNT_W'(BCNT_RESET);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MOD;
      ST_MOD:   if (mod_done) state_next = ST_HEAD;
      ST_HEAD:  state_next = chain_end ? ST_DONE : ST_CHAIN;
      ST_CHAIN: if (resolve) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Walk, update and result logic
  always_comb begin
    head_now   = head_vld_rd ? head_rd : LINK_NULL;
    pool_empty = (next_free == PTR_W'(POOL_ENTRIES));
    chain_hit  = (state == ST_CHAIN) && (ent_rd.key == key_q);
    chain_end  = ((state == ST_HEAD) && (head_now == LINK_NULL)) ||
                 ((state == ST_CHAIN) && !chain_hit && (ent_rd.link == LINK_NULL));
    resolve    = chain_hit || chain_end;
    link_in    = (state == ST_HEAD) ? head_now : head_q;
    ent_raddr  = (state == ST_HEAD) ? head_now[IDX_W-1:0] : ent_rd.link[IDX_W-1:0];
    cnt_inc    = (ent_rd.cnt != COUNT_MAX) ? ent_rd.cnt + 1'b1 : ent_rd.cnt;

    ent_we         = 1'b0;
    ent_waddr      = ptr[IDX_W-1:0];
    ent_wdata      = ent_rd;
    head_we        = 1'b0;
    res_count_next = '0;
    res_found_next = 1'b0;
    res_full_next  = 1'b0;

    if (chain_hit) begin
      // Count a hit in place; a search just reports.
      res_found_next = 1'b1;
      if (cmd_q == CMD_INSERT) begin
        ent_we         = 1'b1;
        ent_wdata.cnt  = cnt_inc;
        res_count_next = cnt_inc;
      end else begin
        res_count_next = ent_rd.cnt;
      end
    end else if (chain_end && (cmd_q == CMD_INSERT)) begin
      if (pool_empty) begin
        res_full_next = 1'b1;
      end else begin
        // Link a fresh entry at the chain head.
        ent_we         = 1'b1;
        ent_waddr      = next_free[IDX_W-1:0];
        ent_wdata.key  = key_q;
        ent_wdata.cnt  = CNT_W'(1);
        ent_wdata.link = link_in;
        head_we        = 1'b1;
        res_count_next = CNT_W'(1);
      end
    end

    out_load = (state == ST_DONE) && out_free;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_vld  <= '0;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (head_we) begin
        head_vld[bucket] <= 1'b1;
        next_free        <= next_free + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      key_q <= key;
    end
    if (state == ST_HEAD) begin
      head_q <= head_now;
      ptr    <= head_now;
    end else if ((state == ST_CHAIN) && !resolve) begin
      ptr <= ent_rd.link;
    end
    if (resolve) begin
      res_count <= res_count_next;
      res_found <= res_found_next;
      res_full  <= res_full_next;
    end
    if (out_load) begin
      count     <= res_count;
      found     <= res_found;
      pool_full <= res_full;
    end
  end

  // Head memory: read as the remainder settles, write on a new link
  always_ff @(posedge clk) begin
    head_rd     <= head_mem[bucket];
    head_vld_rd <= head_vld[bucket];
    if (head_we) begin
      head_mem[bucket] <= next_free;
    end
  end

  // Entry memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    ent_rd <= entry_mem[ent_raddr];
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= PTR_W'(POOL_ENTRIES))
    else $error("pool fill count beyond pool size");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && pool_full |-> !found && (count == '0))
    else $error("dropped insert reports a count");

  a_link_room: assert property (@(posedge clk) disable iff (rst)
    head_we |-> !pool_empty && (cmd_q == CMD_INSERT))
    else $error("link of a new entry into a full pool");

  a_mod_timing: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MOD))
    else $error("remainder finished outside its wait state");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    resolve |=> (state == ST_DONE))
    else $error("resolved walk did not reach result hand-over");

endmodule

### tb/cht_tally_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_tally_checker
// Watches the input, output and configuration ports of the hash table unit,
// predicts the count, found and pool_full of every accepted transaction and
// compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module cht_tally_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            command,
  input  cht_pkg::key_t   key,
  input  logic            out_valid,
  input  logic            out_stall,
  input  cht_pkg::count_t count,
  input  logic            found,
  input  logic            pool_full,
  input  logic            cfg_we,
  input  cht_pkg::bcnt_t  cfg_wdata,
  output int              errors,
  output int              pending
);
  import cht_pkg::*;

  typedef struct packed {
    count_t cnt;
    logic   hit;
    logic   dropped;
  } tally_t;

  bcnt_t       modulus_reg;
  ptr_t        chain_head [MAX_BUCKETS];
  logic [31:0] slot_key   [POOL_ENTRIES];
  count_t      slot_count [POOL_ENTRIES];
  ptr_t        slot_link  [POOL_ENTRIES];
  int unsigned slots_used;
  int          mismatches = 0;
  tally_t      tally_q [$];

  // |key| mod the clamped bucket count; |-2^31| is 2^31 as an unsigned value.
  function automatic bkt_t bucket_for(input logic [31:0] k);
    logic [31:0] mag;
    int unsigned n;
    mag = k[31] ? (32'd0 - k) : k;
    n = modulus_reg;
    if (n == 0) n = 1;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    return bkt_t'(mag % n);
  endfunction

  function automatic ptr_t lookup_slot(input bkt_t b, input logic [31:0] k);
    ptr_t p;
    int   steps;
    p = chain_head[b];
    steps = 0;
    while (p < POOL_ENTRIES && steps < POOL_ENTRIES) begin
      if (slot_key[p] == k) return p;
      p = slot_link[p];
      steps++;
    end
    return LINK_NULL;
  endfunction

  // Apply one transaction to the shadow table and return its result.
  function automatic tally_t count_key(input cmd_t op, input logic [31:0] k);
    tally_t r;
    bkt_t   b;
    ptr_t   e;
    r = '0;
    b = bucket_for(k);
    e = lookup_slot(b, k);
    if (e != LINK_NULL) begin
      r.hit = 1'b1;
      if (op == CMD_INSERT && slot_count[e] != COUNT_MAX) slot_count[e] = slot_count[e] + 1;
      r.cnt = slot_count[e];
    end else if (op == CMD_INSERT) begin
      if (slots_used >= POOL_ENTRIES) begin
        r.dropped = 1'b1;
      end else begin
        slot_key[slots_used]   = k;
        slot_count[slots_used] = 1;
        slot_link[slots_used]  = chain_head[b];
        chain_head[b]          = ptr_t'(slots_used);
        slots_used++;
        r.cnt = 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tally_t want;
    if (rst) begin
      modulus_reg = bcnt_t'(BCNT_RESET);
      for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = LINK_NULL;
      slots_used = 0;
      tally_q.delete();
    end else begin
      // Check the result first: it can never belong to a transaction
      // accepted at this same edge.
      if (out_valid && !out_stall) begin
        if (tally_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: count %0d found %0b pool_full %0b",
                     $realtime, count, found, pool_full);
        end else begin
          want = tally_q.pop_front();
          if (count !== want.cnt || found !== want.hit || pool_full !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: count %0d/%0d found %0b/%0b pool_full %0b/%0b (exp/got)",
                       $realtime, want.cnt, count, want.hit, found, want.dropped, pool_full);
          end
        end
      end
      // A transaction accepted at this edge still hashes with the old count.
      if (in_valid && !in_stall) tally_q.push_back(count_key(cmd_t'(command), key));
      if (cfg_we) modulus_reg = cfg_wdata;
    end
    errors  <= mismatches;
    pending <= tally_q.size();
  end

endmodule

### tb/chained_counting_hash_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_counting_hash_table_unit_test
// Drives insert and search transactions into the hash table unit under
// several bucket counts, with random gaps on the sender and random stalls on
// the receiver; a checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module chained_counting_hash_table_unit_test;
  import cht_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;
  // Keep inserting mostly new keys until the inserts of fresh keys exceed the
  // pool size by a margin of 48.
  localparam int FILL_TARGET     = POOL_ENTRIES + 48;

  logic   clk;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  logic   command   = CMD_INSERT;
  key_t   key       = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  count_t count;
  logic   found;
  logic   pool_full;
  logic   cfg_we    = 1'b0;
  bcnt_t  cfg_wdata = '0;
  int     errors;
  int     pending;

  key_t   stored_keys [$];   // every key sent with an insert, for hits
  int     fresh_sent  = 0;   // inserts of freshly drawn keys
  bcnt_t  bucket_plan [PHASES];
  logic   steady;

  chained_counting_hash_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .found     (found),
    .pool_full (pool_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cht_tally_checker u_tally (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .found     (found),
    .pool_full (pool_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one transaction and hold it until accepted. Valid stays high on
  // return; the caller lowers it only when a gap or a drain follows.
  task automatic issue(input cmd_t op, input key_t k);
    in_valid <= 1'b1;
    command  <= op;
    key      <= k;
    do @(posedge clk); while (in_stall);
    if (op == CMD_INSERT) stored_keys.push_back(k);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has been delivered. Wait on the
  // clock first so that a transaction accepted just now is counted.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_buckets(input bcnt_t n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Fresh keys: full-range random, the extremes, and small magnitudes of
  // both signs so that chains collide and both signs share a bucket.
  function automatic key_t fresh_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh8000_0001;
        3:       return 32'sh7FFF_FFFE;
        4:       return -1;
        default: return 0;
      endcase
    end
    if (r < 33) return key_t'(int'($urandom_range(0, 4000)) - 2000);
    return key_t'($urandom);
  endfunction

  function automatic key_t known_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic random_item();
    int r;
    int fresh_pct;
    fresh_pct = (fresh_sent < FILL_TARGET) ? 90 : 30;
    r = $urandom_range(0, 99);
    if (r < fresh_pct) begin
      fresh_sent++;
      issue(CMD_INSERT, fresh_key());
    end else begin
      case ($urandom_range(0, 2))
        0:       issue(CMD_INSERT, known_key());
        1:       issue(CMD_SEARCH, known_key());
        default: issue(CMD_SEARCH, fresh_key());
      endcase
    end
  endtask

  // Receiver: stall in bursts of random length, mostly short, a few long,
  // and leave long stall-free stretches now and then.
  initial begin : receiver
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      repeat (r < 12 ? $urandom_range(40, 200) : $urandom_range(1, 6)) @(posedge clk);
      r = $urandom_range(0, 99);
      out_stall <= 1'b1;
      repeat (r < 70 ? $urandom_range(1, 3) :
              r < 93 ? $urandom_range(4, 12) : $urandom_range(20, 60)) @(posedge clk);
    end
  end

  initial begin : stimulus
    // Bucket counts per phase: zero (treated as one), one, above the table
    // size (clamped), the table size, two, two random settings, and a few
    // odd ones; the last phase returns to the reset value.
    bucket_plan = '{9'd0, 9'd1, 9'd511, 9'd256, 9'd2, 9'd0, 9'd0, 9'd37, 9'd255, 9'd100};
    bucket_plan[5] = bcnt_t'($urandom_range(0, 511));
    bucket_plan[6] = bcnt_t'($urandom_range(0, 511));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset bucket count of 100.
    issue(CMD_SEARCH, 0);                 // empty table: absent
    issue(CMD_INSERT, 0);                 // new key, count 1
    issue(CMD_INSERT, 0);                 // present, count 2
    issue(CMD_INSERT, 32'sh7FFF_FFFF);    // most positive key
    issue(CMD_INSERT, 32'sh8000_0000);    // most negative key, magnitude 2^31
    issue(CMD_INSERT, -1);
    issue(CMD_INSERT, 1);                 // same bucket as -1: chain grows
    issue(CMD_INSERT, 101);
    issue(CMD_INSERT, -201);
    issue(CMD_SEARCH, 1);                 // middle of the chain
    issue(CMD_SEARCH, -1);                // tail of the chain
    issue(CMD_INSERT, -1);                // count a tail entry
    issue(CMD_SEARCH, 301);               // absent: walk the whole chain
    issue(CMD_SEARCH, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sh7FFF_FFFF);
    issue(CMD_SEARCH, 32'sh8000_0001);    // absent, shares a bucket with the maximum
    issue(CMD_SEARCH, 32'sh7FFF_FFFF);
    fresh_sent = 8;
    // Saturation of a count needs 2^32 inserts of one key and stays out of
    // reach of any run; the predictor still models it.

    // Random phases. Each one starts from an idle unit so that the bucket
    // count changes while entries are stored and earlier keys may be missed.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_buckets(bucket_plan[ph]);
      steady = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item();
        if (!steady) pause_sender(sender_gap());
      end
    end

    drain();
    repeat (64) @(posedge clk);   // catch any stray result
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with full-length chains.
  initial begin : watchdog
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
